### sv/lzw_pkg.sv
package lzw_pkg;

    // Input kinds as they arrive on the item port
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam int CODE_W    = 12;
    localparam int KEY_W     = 20;
    localparam int EPOCH_W   = 8;
    localparam int DIV_W     = 25;

    localparam logic [12:0] CLEAR_LIMIT = 13'd4095;
    localparam logic [3:0]  MCS_RESET   = 4'd8;
    localparam logic [3:0]  MCS_MIN     = 4'd2;
    localparam logic [3:0]  MCS_MAX     = 4'd8;
    localparam logic [3:0]  WIDTH_MAX   = 4'd12;

    // Register index of the minimum code size
    localparam logic REG_MCS = 1'b0;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] pixel_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       image_end;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_START,
        OP_FINISH,
        OP_NOP
    } t_op;

    // One classified command between the front and the back
    typedef struct packed {
        t_op        op;
        logic [7:0] pix;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_RD,
        S_CHK,
        S_PUT,
        S_EMIT,
        S_FLUSH,
        S_WIPE,
        S_END
    } t_state;

    typedef enum logic [2:0] {
        PH_START_CLR,
        PH_MISS_PREFIX,
        PH_MISS_CLEAR,
        PH_FIN_PREFIX,
        PH_FIN_END
    } t_phase;

endpackage

### sv/lzw_front.sv
module lzw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lzw_pkg::t_in_item i_item,
    input  logic              i_block,
    output logic              o_full,
    output lzw_pkg::t_cmd     o_cmd,
    output logic              o_cmd_vld,
    input  logic              i_cmd_pop
);

    lzw_pkg::t_cmd r_slot [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_count;
    lzw_pkg::t_cmd cls;
    logic          acc_beat;
    logic          pop_beat;

    // Classify the raw kind into an operation
    always_comb begin
        cls.pix = i_item.pixel_value;
        unique case (i_item.kind)
            lzw_pkg::KIND_PIXEL:  cls.op = lzw_pkg::OP_PIXEL;
            lzw_pkg::KIND_START:  cls.op = lzw_pkg::OP_START;
            lzw_pkg::KIND_FINISH: cls.op = lzw_pkg::OP_FINISH;
            default:              cls.op = lzw_pkg::OP_NOP;
        endcase
    end

    assign o_full    = (r_count == 2'd2) || i_block;
    assign acc_beat  = i_push && !o_full;
    assign pop_beat  = i_cmd_pop && (r_count != 2'd0);
    assign o_cmd_vld = (r_count != 2'd0);
    assign o_cmd     = r_slot[r_rd];

    // Two-entry command queue
    always_ff @(posedge i_clk) begin
        if (acc_beat) begin
            r_slot[r_wr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (acc_beat) begin
                r_wr <= ~r_wr;
            end
            if (pop_beat) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(acc_beat) - 2'(pop_beat);
        end
    end

endmodule

### sv/lzw_ofifo.sv
module lzw_ofifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lzw_pkg::t_out_item i_data,
    output logic               o_full,
    output logic               o_empty,
    output lzw_pkg::t_out_item o_data,
    input  logic               i_pop
);

    lzw_pkg::t_out_item r_mem [4];
    logic [1:0]         r_wr;
    logic [1:0]         r_rd;
    logic [2:0]         r_count;
    logic               wr_beat;
    logic               rd_beat;

    assign o_full  = (r_count == 3'd4);
    assign o_empty = (r_count == 3'd0);
    assign o_data  = r_mem[r_rd];
    assign wr_beat = i_push && !o_full;
    assign rd_beat = i_pop && !o_empty;

    // Result storage
    always_ff @(posedge i_clk) begin
        if (wr_beat) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 2'd0;
            r_rd    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            if (wr_beat) begin
                r_wr <= r_wr + 2'd1;
            end
            if (rd_beat) begin
                r_rd <= r_rd + 2'd1;
            end
            r_count <= r_count + 3'(wr_beat) - 3'(rd_beat);
        end
    end

endmodule

### sv/lzw_core.sv
module lzw_core #(
    parameter int HASH_ENTRIES = 8192
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [3:0]         i_mcs,
    input  lzw_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_vld,
    output logic               o_cmd_pop,
    output logic               o_init,
    output logic               o_push,
    output lzw_pkg::t_out_item o_pdata,
    input  logic               i_ofull
);

    localparam int HB      = $clog2(HASH_ENTRIES);
    localparam bit IS_POW2 = (HASH_ENTRIES == (1 << HB));
    localparam int ENTRY_W = lzw_pkg::EPOCH_W + lzw_pkg::KEY_W + lzw_pkg::CODE_W;
    localparam logic [lzw_pkg::DIV_W-1:0] N_EXT = lzw_pkg::DIV_W'(HASH_ENTRIES);
    localparam logic [20:0] RECIP = 21'((64'd1 << 32) / 64'(HASH_ENTRIES));
    localparam logic [HB-1:0] H_LAST = HB'(HASH_ENTRIES - 1);
    localparam logic [lzw_pkg::EPOCH_W-1:0] EPOCH_LAST = '1;

    // Dictionary: {epoch, key, code}; an entry is live when its epoch matches
    logic [ENTRY_W-1:0] r_dict [HASH_ENTRIES];
    logic [ENTRY_W-1:0] r_rdata;
    logic               mem_we;
    logic [HB-1:0]      mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;

    lzw_pkg::t_state r_state, n_state;
    lzw_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_size, n_size;
    logic        r_active, n_active;
    logic        r_have, n_have;
    logic [11:0] r_prefix, n_prefix;
    logic [12:0] r_nfc, n_nfc;
    logic [3:0]  r_width, n_width;
    logic [31:0] r_acc, n_acc;
    logic [4:0]  r_cnt, n_cnt;
    logic [11:0] r_code, n_code;
    logic [7:0]  r_pix, n_pix;
    logic [19:0] r_key, n_key;
    logic [lzw_pkg::DIV_W-1:0] r_rem, n_rem;
    logic [2:0]  r_step, n_step;
    logic [HB-1:0] r_h, n_h;
    logic [lzw_pkg::EPOCH_W-1:0] r_epoch, n_epoch;
    logic        r_init, n_init;
    logic [HB-1:0] r_wipe, n_wipe;
    logic        r_hold_vld, n_hold_vld;
    logic [7:0]  r_hold, n_hold;
    logic        r_fin, n_fin;

    logic [3:0]  s_clamp;
    logic [7:0]  pm;
    logic [19:0] key_c;
    logic [19:0] hx;
    logic [19:0] hx_k;
    logic [39:0] q_prod;
    logic [lzw_pkg::DIV_W-1:0] qn;
    logic        emit_req;
    logic [7:0]  emit_byte;
    logic        emit_ok;
    logic        clr_req;
    logic [lzw_pkg::EPOCH_W-1:0] e_epoch;
    logic [19:0] e_key;
    logic [11:0] e_code;

    assign o_init = r_init;
    assign emit_ok = !r_hold_vld || !i_ofull;
    assign {e_epoch, e_key, e_code} = r_rdata;
    assign mem_addr = (r_state == lzw_pkg::S_WIPE) ? r_wipe : r_h;

    // Dictionary memory, one write port and one read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_dict[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_dict[r_h];
    end

    always_comb begin
        s_clamp = (i_mcs < lzw_pkg::MCS_MIN) ? lzw_pkg::MCS_MIN :
                  (i_mcs > lzw_pkg::MCS_MAX) ? lzw_pkg::MCS_MAX : i_mcs;
        pm      = i_cmd.pix & (8'hFF >> (4'd8 - r_size));
        key_c   = {r_prefix, pm};
        hx      = {12'd0, key_c[19:12]} ^ key_c;
        hx_k    = {12'd0, r_key[19:12]} ^ r_key;
        q_prod  = 40'(hx_k) * 40'(RECIP);
        qn      = lzw_pkg::DIV_W'(r_rem[7:0]) * N_EXT;
    end

    // Next state and datapath control
    always_comb begin
        n_state = r_state;   n_phase = r_phase;   n_size = r_size;
        n_active = r_active; n_have = r_have;     n_prefix = r_prefix;
        n_nfc = r_nfc;       n_width = r_width;   n_acc = r_acc;
        n_cnt = r_cnt;       n_code = r_code;     n_pix = r_pix;
        n_key = r_key;       n_rem = r_rem;       n_step = r_step;
        n_h = r_h;           n_epoch = r_epoch;   n_init = r_init;
        n_wipe = r_wipe;     n_hold_vld = r_hold_vld;
        n_hold = r_hold;     n_fin = r_fin;
        o_cmd_pop = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = {r_epoch, r_key, r_nfc[11:0]};
        emit_req  = 1'b0;
        emit_byte = r_acc[7:0];
        clr_req   = 1'b0;
        o_push    = 1'b0;
        o_pdata   = '{out_byte: r_hold, last: 1'b0, image_end: 1'b0};

        unique case (r_state)
            lzw_pkg::S_IDLE: begin
                if (i_cmd_vld) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        lzw_pkg::OP_START: begin
                            n_size     = s_clamp;
                            n_active   = 1'b1;
                            n_have     = 1'b0;
                            n_prefix   = 12'd0;
                            n_nfc      = (13'd1 << s_clamp) + 13'd2;
                            n_width    = s_clamp + 4'd1;
                            n_acc      = 32'd0;
                            n_cnt      = 5'd0;
                            n_fin      = 1'b0;
                            n_hold     = {4'd0, s_clamp};
                            n_hold_vld = 1'b1;
                            n_code     = 12'd1 << s_clamp;
                            n_phase    = lzw_pkg::PH_START_CLR;
                            n_state    = lzw_pkg::S_PUT;
                        end
                        lzw_pkg::OP_PIXEL: begin
                            if (r_active) begin
                                n_pix = pm;
                                if (!r_have) begin
                                    n_prefix = {4'd0, pm};
                                    n_have   = 1'b1;
                                end else begin
                                    n_key  = key_c;
                                    n_step = 3'd2;
                                    if (IS_POW2) begin
                                        n_h     = hx[HB-1:0];
                                        n_state = lzw_pkg::S_RD;
                                    end else begin
                                        n_state = lzw_pkg::S_HASH;
                                    end
                                end
                            end
                        end
                        lzw_pkg::OP_FINISH: begin
                            if (r_active) begin
                                n_fin = 1'b1;
                                if (r_have) begin
                                    n_code  = r_prefix;
                                    n_phase = lzw_pkg::PH_FIN_PREFIX;
                                end else begin
                                    n_code  = (12'd1 << r_size) + 12'd1;
                                    n_phase = lzw_pkg::PH_FIN_END;
                                end
                                n_state = lzw_pkg::S_PUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            lzw_pkg::S_HASH: begin
                // Table-size remainder by reciprocal multiplication
                if (r_step == 3'd2) begin
                    n_rem  = lzw_pkg::DIV_W'(q_prod[39:32]);
                    n_step = 3'd1;
                end else if (r_step == 3'd1) begin
                    n_rem  = lzw_pkg::DIV_W'(hx_k) - qn;
                    n_step = 3'd0;
                end else begin
                    n_h     = (r_rem >= N_EXT) ? HB'(r_rem - N_EXT) : r_rem[HB-1:0];
                    n_state = lzw_pkg::S_RD;
                end
            end
            lzw_pkg::S_RD: begin
                n_state = lzw_pkg::S_CHK;
            end
            lzw_pkg::S_CHK: begin
                if (e_epoch != r_epoch) begin
                    n_code  = r_prefix;
                    n_phase = lzw_pkg::PH_MISS_PREFIX;
                    n_state = lzw_pkg::S_PUT;
                end else if (e_key == r_key) begin
                    n_prefix = e_code;
                    n_state  = lzw_pkg::S_END;
                end else begin
                    n_h     = (r_h == H_LAST) ? '0 : r_h + HB'(1);
                    n_state = lzw_pkg::S_RD;
                end
            end
            lzw_pkg::S_PUT: begin
                n_acc   = r_acc | (32'(r_code) << r_cnt);
                n_cnt   = r_cnt + {1'b0, r_width};
                n_state = lzw_pkg::S_EMIT;
            end
            lzw_pkg::S_EMIT: begin
                if (r_cnt >= 5'd8) begin
                    emit_req = 1'b1;
                    if (emit_ok) begin
                        n_acc = r_acc >> 8;
                        n_cnt = r_cnt - 5'd8;
                    end
                end else begin
                    if (r_width < lzw_pkg::WIDTH_MAX && r_nfc >= (13'd1 << r_width)) begin
                        n_width = r_width + 4'd1;
                    end
                    unique case (r_phase)
                        lzw_pkg::PH_START_CLR: begin
                            clr_req = 1'b1;
                        end
                        lzw_pkg::PH_MISS_PREFIX: begin
                            n_prefix = {4'd0, r_pix};
                            if (r_nfc >= lzw_pkg::CLEAR_LIMIT) begin
                                n_code  = 12'd1 << r_size;
                                n_phase = lzw_pkg::PH_MISS_CLEAR;
                                n_state = lzw_pkg::S_PUT;
                            end else begin
                                mem_we  = 1'b1;
                                n_nfc   = r_nfc + 13'd1;
                                n_state = lzw_pkg::S_END;
                            end
                        end
                        lzw_pkg::PH_MISS_CLEAR: begin
                            n_nfc   = (13'd1 << r_size) + 13'd2;
                            n_width = r_size + 4'd1;
                            clr_req = 1'b1;
                        end
                        lzw_pkg::PH_FIN_PREFIX: begin
                            n_code  = (12'd1 << r_size) + 12'd1;
                            n_phase = lzw_pkg::PH_FIN_END;
                            n_state = lzw_pkg::S_PUT;
                        end
                        lzw_pkg::PH_FIN_END: begin
                            n_state = lzw_pkg::S_FLUSH;
                        end
                        default: ;
                    endcase
                end
            end
            lzw_pkg::S_FLUSH: begin
                if (r_cnt != 5'd0) begin
                    emit_req = 1'b1;
                    if (emit_ok) begin
                        n_acc = r_acc >> 8;
                        n_cnt = (r_cnt >= 5'd8) ? r_cnt - 5'd8 : 5'd0;
                    end
                end else begin
                    n_acc    = 32'd0;
                    n_active = 1'b0;
                    n_have   = 1'b0;
                    n_state  = lzw_pkg::S_END;
                end
            end
            lzw_pkg::S_WIPE: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (r_wipe == H_LAST) begin
                    n_epoch = lzw_pkg::EPOCH_W'(1);
                    n_init  = 1'b0;
                    n_state = lzw_pkg::S_END;
                end else begin
                    n_wipe = r_wipe + HB'(1);
                end
            end
            lzw_pkg::S_END: begin
                // Last beat of the item leaves the hold register
                if (r_hold_vld) begin
                    o_pdata = '{out_byte: r_hold, last: 1'b1, image_end: r_fin};
                    if (!i_ofull) begin
                        o_push     = 1'b1;
                        n_hold_vld = 1'b0;
                        n_state    = lzw_pkg::S_IDLE;
                    end
                end else begin
                    n_state = lzw_pkg::S_IDLE;
                end
            end
            default: n_state = lzw_pkg::S_IDLE;
        endcase

        // A byte forces the previous one out as a non-final beat
        if (emit_req && emit_ok) begin
            o_push     = r_hold_vld;
            n_hold     = emit_byte;
            n_hold_vld = 1'b1;
        end

        // Emptying the dictionary moves to a new epoch, sweeping on wrap
        if (clr_req) begin
            if (r_epoch == EPOCH_LAST) begin
                n_wipe  = '0;
                n_state = lzw_pkg::S_WIPE;
            end else begin
                n_epoch = r_epoch + lzw_pkg::EPOCH_W'(1);
                n_state = lzw_pkg::S_END;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lzw_pkg::S_WIPE;
            r_phase    <= lzw_pkg::PH_START_CLR;
            r_size     <= lzw_pkg::MCS_RESET;
            r_active   <= 1'b0;
            r_have     <= 1'b0;
            r_prefix   <= 12'd0;
            r_nfc      <= 13'd0;
            r_width    <= 4'd9;
            r_acc      <= 32'd0;
            r_cnt      <= 5'd0;
            r_epoch    <= lzw_pkg::EPOCH_W'(1);
            r_init     <= 1'b1;
            r_wipe     <= '0;
            r_hold_vld <= 1'b0;
            r_fin      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_size     <= n_size;
            r_active   <= n_active;
            r_have     <= n_have;
            r_prefix   <= n_prefix;
            r_nfc      <= n_nfc;
            r_width    <= n_width;
            r_acc      <= n_acc;
            r_cnt      <= n_cnt;
            r_epoch    <= n_epoch;
            r_init     <= n_init;
            r_wipe     <= n_wipe;
            r_hold_vld <= n_hold_vld;
            r_fin      <= n_fin;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_pix  <= n_pix;
        r_key  <= n_key;
        r_rem  <= n_rem;
        r_step <= n_step;
        r_h    <= n_h;
        r_hold <= n_hold;
    end

    // Between items no whole byte is left in the accumulator
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lzw_pkg::S_IDLE |-> r_cnt < 5'd8)
        else $error("whole byte left in accumulator between items");

    // Every item ends with its final beat delivered
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lzw_pkg::S_IDLE |-> !r_hold_vld)
        else $error("byte still held while idle");

    // The next free code stays at most one above the clear limit
    a_nfc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_nfc <= lzw_pkg::CLEAR_LIMIT + 13'd1)
        else $error("next free code out of range");

    // Code width stays within one above the image size and twelve
    a_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_width <= lzw_pkg::WIDTH_MAX && r_width > r_size))
        else $error("code width out of range");

    // Commands are taken only from the idle state
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == lzw_pkg::S_IDLE && !r_init))
        else $error("command taken while busy");

endmodule

### sv/lzw_pixel_encoder.sv
// GIF LZW encoder with codes of up to twelve bits.
// Input channel: push/full queue of items (kind, pixel_value). Kind start
// begins an image, pixel extends the current string, finish closes it.
// Result channel: empty/pop queue of beats (out_byte, last, image_end);
// last marks the final beat caused by an item, image_end the final beat
// of an image. The minimum code size register sits at APB address 0.
// A pixel may need a table-size remainder (skipped for a power-of-two
// table), then hash probes, each a read and a check, on the dictionary
// port, and for each code a packing step, the output of its whole bytes
// and a closing step, plus a final step that hands over the last beat.
// After reset the dictionary is swept once while full stays high. Emptying
// the dictionary bumps an epoch tag; every 255th time it also sweeps the table.
// A two-entry command queue lets items arrive while the back end works,
// and a four-beat result queue absorbs a stalled receiver; when it fills,
// the back end waits and the command queue then raises full.
module lzw_pixel_encoder #(
    parameter int HASH_ENTRIES = 8192
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  lzw_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output lzw_pkg::t_out_item o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [3:0]         r_mcs;
    lzw_pkg::t_cmd      cmd;
    logic               cmd_vld;
    logic               cmd_pop;
    logic               init;
    logic               opush;
    logic               ofull;
    lzw_pkg::t_out_item pdata;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == lzw_pkg::REG_MCS) ? {28'd0, r_mcs} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcs <= lzw_pkg::MCS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == lzw_pkg::REG_MCS) begin
            r_mcs <= pwdata[3:0];
        end
    end

    lzw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .i_block   (init),
        .o_full    (full),
        .o_cmd     (cmd),
        .o_cmd_vld (cmd_vld),
        .i_cmd_pop (cmd_pop)
    );

    lzw_core #(
        .HASH_ENTRIES (HASH_ENTRIES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mcs     (r_mcs),
        .i_cmd     (cmd),
        .i_cmd_vld (cmd_vld),
        .o_cmd_pop (cmd_pop),
        .o_init    (init),
        .o_push    (opush),
        .o_pdata   (pdata),
        .i_ofull   (ofull)
    );

    lzw_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (opush),
        .i_data  (pdata),
        .o_full  (ofull),
        .o_empty (empty),
        .o_data  (o_result),
        .i_pop   (pop)
    );

endmodule

### verif/tb_lzw_pixel_encoder.sv
`timescale 1ns / 100ps

module tb_lzw_pixel_encoder;

    localparam int TABLE_SLOTS = 8192;
    localparam int STALL_LIMIT = 40000;
    localparam int SETTLE_CYCLES = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    lzw_pkg::t_in_item  i_item = '0;
    logic               empty;
    logic               pop = 1'b0;
    lzw_pkg::t_out_item o_result;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    lzw_pixel_encoder u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    // Encoder state as predicted by the testbench.
    logic [31:0] enc_dict [TABLE_SLOTS];
    int unsigned enc_prefix, enc_next_code, enc_width, enc_acc, enc_nbits;
    int unsigned enc_cfg_size, enc_img_size;
    bit          enc_have_prefix, enc_active;
    lzw_pkg::t_out_item item_beats[$];
    lzw_pkg::t_out_item expected_beats[$];

    int errors = 0;
    int burst_left = 0;
    int hold_req = 0;

    function automatic void dict_wipe();
        foreach (enc_dict[i]) enc_dict[i] = 32'hFFFF_FFFF;
    endfunction

    function automatic int dict_find(int unsigned key);
        int unsigned h;
        h = ((key >> 12) ^ key) % TABLE_SLOTS;
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            if ((enc_dict[h] >> 12) == 32'hFFFFF) return -1;
            if ((enc_dict[h] >> 12) == key) return int'(enc_dict[h] & 32'hFFF);
            h = (h + 1) % TABLE_SLOTS;
        end
        return -1;
    endfunction

    function automatic void dict_insert(int unsigned key, int unsigned code);
        int unsigned h;
        h = ((key >> 12) ^ key) % TABLE_SLOTS;
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            if ((enc_dict[h] >> 12) == 32'hFFFFF) begin
                enc_dict[h] = (key << 12) | (code & 32'hFFF);
                return;
            end
            h = (h + 1) % TABLE_SLOTS;
        end
    endfunction

    function automatic void beat_out(int unsigned b);
        lzw_pkg::t_out_item r;
        if (item_beats.size() >= 4) return;
        r = '0;
        r.out_byte = b[7:0];
        item_beats.push_back(r);
    endfunction

    // Pack one code LSB first and grow the code width when it is due.
    function automatic void pack_code(int unsigned code);
        enc_acc |= (code & 32'hFFF) << enc_nbits;
        enc_nbits += enc_width;
        while (enc_nbits >= 8) begin
            beat_out(enc_acc & 8'hFF);
            enc_acc >>= 8;
            enc_nbits -= 8;
        end
        if (enc_width < 12 && enc_next_code >= (1 << enc_width)) enc_width++;
    endfunction

    // Work out the beats that one accepted item causes.
    function automatic void predict_item(lzw_pkg::t_in_item it);
        int unsigned clr, pix, key;
        int found;
        item_beats.delete();
        pix = it.pixel_value;
        if (it.kind == lzw_pkg::KIND_START) begin
            enc_img_size = enc_cfg_size < 2 ? 2 : (enc_cfg_size > 8 ? 8 : enc_cfg_size);
            enc_active = 1;
            enc_have_prefix = 0;
            enc_prefix = 0;
            enc_next_code = (1 << enc_img_size) + 2;
            enc_width = enc_img_size + 1;
            enc_acc = 0;
            enc_nbits = 0;
            beat_out(enc_img_size);
            dict_wipe();
            pack_code(1 << enc_img_size);
        end else if (it.kind == lzw_pkg::KIND_PIXEL && enc_active) begin
            clr = 1 << enc_img_size;
            pix &= clr - 1;
            if (!enc_have_prefix) begin
                enc_prefix = pix;
                enc_have_prefix = 1;
            end else begin
                key = ((enc_prefix & 32'hFFF) << 8) | pix;
                found = dict_find(key);
                if (found >= 0) begin
                    enc_prefix = found;
                end else begin
                    pack_code(enc_prefix);
                    enc_prefix = pix;
                    if (enc_next_code >= lzw_pkg::CLEAR_LIMIT) begin
                        pack_code(clr);
                        enc_next_code = clr + 2;
                        enc_width = enc_img_size + 1;
                        dict_wipe();
                    end else begin
                        dict_insert(key, enc_next_code);
                        enc_next_code++;
                    end
                end
            end
        end else if (it.kind == lzw_pkg::KIND_FINISH && enc_active) begin
            clr = 1 << enc_img_size;
            if (enc_have_prefix) pack_code(enc_prefix);
            pack_code(clr + 1);
            while (enc_nbits > 0) begin
                beat_out(enc_acc & 8'hFF);
                enc_acc >>= 8;
                enc_nbits = enc_nbits >= 8 ? enc_nbits - 8 : 0;
            end
            enc_acc = 0;
            enc_active = 0;
            enc_have_prefix = 0;
            if (item_beats.size() > 0) item_beats[item_beats.size() - 1].image_end = 1'b1;
        end
        if (item_beats.size() > 0) item_beats[item_beats.size() - 1].last = 1'b1;
        foreach (item_beats[i]) expected_beats.push_back(item_beats[i]);
    endfunction

    // Offer one item in bursts with random gaps; predict it once accepted.
    task automatic send_item(logic [1:0] kind, logic [7:0] pix);
        lzw_pkg::t_in_item it;
        it.kind = kind;
        it.pixel_value = pix;
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 12);
        end
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        predict_item(it);
        burst_left--;
    endtask

    // Wait until every expected beat has come out, then let the block settle.
    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_code_size(logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {lzw_pkg::REG_MCS, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        enc_cfg_size = value & 32'hF;
    endtask

    task automatic send_image(int npix, int unsigned bits);
        send_item(lzw_pkg::KIND_START, 8'($urandom()));
        repeat (npix) send_item(lzw_pkg::KIND_PIXEL, 8'($urandom_range(0, (1 << bits) - 1)));
        send_item(lzw_pkg::KIND_FINISH, 8'($urandom()));
    endtask

    // Extremes, every kind and the named corner cases.
    task automatic test_directed();
        send_item(lzw_pkg::KIND_PIXEL, 8'h12);
        send_item(lzw_pkg::KIND_FINISH, 8'h00);
        send_item(lzw_pkg::KIND_START, 8'h00);
        send_item(lzw_pkg::KIND_PIXEL, 8'h00);
        send_item(lzw_pkg::KIND_PIXEL, 8'hFF);
        send_item(lzw_pkg::KIND_PIXEL, 8'h00);
        send_item(lzw_pkg::KIND_PIXEL, 8'hFF);
        send_item(lzw_pkg::KIND_PIXEL, 8'h00);
        send_item(2'd3, 8'hA5);
        send_item(lzw_pkg::KIND_FINISH, 8'hFF);
        send_item(lzw_pkg::KIND_PIXEL, 8'h01);
        send_item(lzw_pkg::KIND_START, 8'hFF);
        send_item(lzw_pkg::KIND_FINISH, 8'h00);
        drain();
        write_code_size(32'd2);
        send_item(lzw_pkg::KIND_START, 8'h00);
        send_item(lzw_pkg::KIND_PIXEL, 8'hFF);
        send_item(lzw_pkg::KIND_PIXEL, 8'hFE);
        send_item(lzw_pkg::KIND_START, 8'h00);
        send_item(lzw_pkg::KIND_PIXEL, 8'h03);
        send_item(lzw_pkg::KIND_FINISH, 8'h00);
        drain();
        write_code_size(32'hFFFF_FFF0);
        send_image(3, 8);
        drain();
        write_code_size(32'h0000_000F);
        send_image(3, 8);
        drain();
    endtask

    // Mostly well-formed images with random content, some noise between and inside them.
    task automatic test_random();
        int unsigned s;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: s = 2;
                1: s = 8;
                2: s = 1;
                default: s = $urandom_range(2, 8);
            endcase
            write_code_size({$urandom_range(0, 1) ? 28'hABCDEF0 : 28'h0, s[3:0]});
            for (int k = 0; k < 4; k++) begin
                if ($urandom_range(0, 3) == 0)
                    send_item(2'($urandom_range(0, 3)), 8'($urandom()));
                send_item(lzw_pkg::KIND_START, 8'($urandom()));
                repeat ($urandom_range(0, 14)) begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(2'($urandom_range(0, 3)), 8'($urandom()));
                    else
                        send_item(lzw_pkg::KIND_PIXEL,
                                  8'($urandom() & ((1 << (s < 2 ? 2 : s)) - 1)));
                end
                if ($urandom_range(0, 7) != 0) send_item(lzw_pkg::KIND_FINISH, 8'($urandom()));
            end
            drain();
        end
    endtask

    // The receiver holds off while the sender keeps pushing.
    task automatic test_backpressure();
        write_code_size(32'd8);
        hold_req = 1;
        send_image(40, 8);
        drain();
    endtask

    // A longer image with a small code size grows the code width several times.
    task automatic test_long_image();
        write_code_size(32'd2);
        send_image(60, 2);
        drain();
    endtask

    // Receiver: a randomly chosen stall mode, redrawn on a tick counter; a long hold-off on request.
    int hold_cnt = 0;
    int rx_mode = 0;
    int rx_tick = 0;
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_cnt = 400;
            hold_req = 0;
        end
        rx_tick++;
        if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 2);
        if (hold_cnt > 0) begin
            hold_cnt--;
            pop <= 1'b0;
        end else begin
            case (rx_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                default: pop <= (rx_tick % 4 == 0);
            endcase
        end
    end

    // Compare each popped beat with the oldest expectation.
    always @(posedge i_clk) begin
        if (pop && !empty) begin
            if (expected_beats.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat %p", o_result);
            end else begin
                if (o_result !== expected_beats[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("beat mismatch: expected %p actual %p",
                                 expected_beats[0], o_result);
                end
                void'(expected_beats.pop_front());
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side.
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) quiet = 0;
        else quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("FAIL lzw_pixel_encoder");
            $finish;
        end
    end

    initial begin
        enc_cfg_size = 8;
        enc_img_size = 8;
        enc_active = 0;
        enc_have_prefix = 0;
        enc_prefix = 0;
        enc_next_code = 0;
        enc_width = 9;
        enc_acc = 0;
        enc_nbits = 0;
        dict_wipe();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        test_long_image();
        drain();
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("PASS lzw_pixel_encoder");
        end else begin
            $display("FAIL lzw_pixel_encoder");
        end
        $finish;
    end

endmodule
